// ===== hdl/tagged_fully_assoc_tlb_top_macros.svh =====
// assertion helpers shared by the checker
`ifndef TAGGED_FULLY_ASSOC_TLB_TOP_MACROS_SVH
`define TAGGED_FULLY_ASSOC_TLB_TOP_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define TFATLB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define TFATLB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tfatlb_pkg.sv =====
// ----------------------------------------------------------------------------
// tfatlb_pkg
// Shared types for the process-tagged fully associative translation buffer.
// ----------------------------------------------------------------------------
package tfatlb_pkg;

    typedef enum logic [1:0] {
        MODE_LOOKUP   = 2'd0,
        MODE_INSERT   = 2'd1,
        MODE_INV_PROC = 2'd2,
        MODE_INV_PAGE = 2'd3
    } t_mode;

    // control part of the request token that walks the cell chain
    typedef struct packed {
        logic  valid;
        t_mode mode;
        logic  fill;   // second pass of an insert that missed
        logic  found;  // hit seen, or free entry taken on the fill pass
    } t_ctl;

endpackage

// ===== hdl/tfatlb_if.sv =====
// ----------------------------------------------------------------------------
// tfatlb_req_if / tfatlb_rsp_if
// Valid/ready channels for translation requests and their results.
// ----------------------------------------------------------------------------
interface tfatlb_req_if #(
    parameter int PROC_BITS  = 16,
    parameter int PAGE_BITS  = 20,
    parameter int FRAME_BITS = 20
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            mode;
    logic [PROC_BITS-1:0]  proc_id;
    logic [PAGE_BITS-1:0]  page_num;
    logic [FRAME_BITS-1:0] frame_in;

    modport source (output valid, output mode, output proc_id, output page_num,
                    output frame_in, input ready);
    modport sink   (input valid, input mode, input proc_id, input page_num,
                    input frame_in, output ready);
endinterface

interface tfatlb_rsp_if #(
    parameter int FRAME_BITS = 20
);
    logic                  valid;
    logic                  ready;
    logic                  ok;
    logic [FRAME_BITS-1:0] frame_out;

    modport source (output valid, output ok, output frame_out, input ready);
    modport sink   (input valid, input ok, input frame_out, output ready);
endinterface

// ===== hdl/tagged_fully_assoc_tlb_top.sv =====
// ----------------------------------------------------------------------------
// tagged_fully_assoc_tlb_top
// Process-tagged fully associative translation buffer built as a chain of
// entry cells that a request token walks, one cell per cycle.
// ----------------------------------------------------------------------------
// a lookup, invalidate or insert hit walks the chain once before its result is
//   registered at the output; an insert that misses walks it a second time
//   to claim the first free entry
// items: a new one is accepted only after the last one has left the chain and
//   its result has been registered; a held result delays this further
// reset: synchronous active-low, clears every valid bit, including the output valid
module tagged_fully_assoc_tlb_top import tfatlb_pkg::*; #(
    parameter int NUM_ENTRIES = 16,
    parameter int PROC_BITS   = 16,
    parameter int PAGE_BITS   = 20,
    parameter int FRAME_BITS  = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tfatlb_req_if.sink    i_req,
    tfatlb_rsp_if.source  o_rsp
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PASS = 4'b0010,
        ST_FILL = 4'b0100,
        ST_WAIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic                  r_out_valid, n_out_valid;
    logic                  r_out_ok,    n_out_ok;
    logic [FRAME_BITS-1:0] r_out_frame, n_out_frame;
    logic                  r_pend_ok,   n_pend_ok;
    logic [FRAME_BITS-1:0] r_pend_frame, n_pend_frame;

    t_ctl                  w_ctl   [NUM_ENTRIES+1];
    logic [PROC_BITS-1:0]  w_proc  [NUM_ENTRIES+1];
    logic [PAGE_BITS-1:0]  w_page  [NUM_ENTRIES+1];
    logic [FRAME_BITS-1:0] w_frame [NUM_ENTRIES+1];

    t_ctl                  w_tail;
    logic                  w_accept;
    logic                  w_refill;
    logic                  w_done;
    logic                  w_res_ok;
    logic [FRAME_BITS-1:0] w_res_frame;
    logic                  w_out_free;

    assign w_tail   = w_ctl[NUM_ENTRIES];
    assign w_accept = i_req.valid && i_req.ready;
    // insert that found no match goes round again to claim a free entry
    assign w_refill = (r_state == ST_PASS) && w_tail.valid && !w_tail.fill
                      && (w_tail.mode == MODE_INSERT) && !w_tail.found;
    assign w_done   = w_tail.valid && !w_refill
                      && ((r_state == ST_PASS) || (r_state == ST_FILL));
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // chain head
    always_comb begin
        w_ctl[0]   = '0;
        w_proc[0]  = i_req.proc_id;
        w_page[0]  = i_req.page_num;
        w_frame[0] = i_req.frame_in;
        if (r_state == ST_IDLE) begin
            w_ctl[0].valid = w_accept;
            w_ctl[0].mode  = t_mode'(i_req.mode);
        end else if (w_refill) begin
            w_ctl[0].valid = 1'b1;
            w_ctl[0].mode  = w_tail.mode;
            w_ctl[0].fill  = 1'b1;
            w_proc[0]      = w_proc[NUM_ENTRIES];
            w_page[0]      = w_page[NUM_ENTRIES];
            w_frame[0]     = w_frame[NUM_ENTRIES];
        end
    end

    for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
        tfatlb_cell #(
            .PROC_BITS  (PROC_BITS),
            .PAGE_BITS  (PAGE_BITS),
            .FRAME_BITS (FRAME_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_proc  (w_proc[g]),
            .i_page  (w_page[g]),
            .i_frame (w_frame[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_proc  (w_proc[g+1]),
            .o_page  (w_page[g+1]),
            .o_frame (w_frame[g+1])
        );
    end

    // result from the token leaving the last cell
    always_comb begin
        w_res_ok    = 1'b1;
        w_res_frame = '0;
        if (w_tail.fill) begin
            w_res_ok = w_tail.found;
        end else begin
            case (w_tail.mode)
                MODE_LOOKUP: begin
                    w_res_ok = w_tail.found;
                    if (w_tail.found) begin
                        w_res_frame = w_frame[NUM_ENTRIES];
                    end
                end
                MODE_INSERT:   w_res_ok = w_tail.found;
                MODE_INV_PROC: w_res_ok = 1'b1;
                MODE_INV_PAGE: w_res_ok = 1'b1;
                default:       w_res_ok = 1'b1;
            endcase
        end
    end

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_ok     = r_out_ok;
        n_out_frame  = r_out_frame;
        n_pend_ok    = r_pend_ok;
        n_pend_frame = r_pend_frame;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_PASS;
                end
            end
            ST_PASS, ST_FILL: begin
                if (w_refill) begin
                    n_state = ST_FILL;
                end else if (w_done) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_ok    = w_res_ok;
                        n_out_frame = w_res_frame;
                        n_state     = ST_IDLE;
                    end else begin
                        n_pend_ok    = w_res_ok;
                        n_pend_frame = w_res_frame;
                        n_state      = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_pend_ok;
                    n_out_frame = r_pend_frame;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_ok     <= n_out_ok;
        r_out_frame  <= n_out_frame;
        r_pend_ok    <= n_pend_ok;
        r_pend_frame <= n_pend_frame;
    end

    assign i_req.ready     = (r_state == ST_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.ok        = r_out_ok;
    assign o_rsp.frame_out = r_out_frame;

endmodule

// ===== hdl/tfatlb_cell.sv =====
// ----------------------------------------------------------------------------
// tfatlb_cell
// One translation entry; compares the passing request token against its
// entry, updates the entry and hands the token to the next cell.
// ----------------------------------------------------------------------------
module tfatlb_cell import tfatlb_pkg::*; #(
    parameter int PROC_BITS  = 16,
    parameter int PAGE_BITS  = 20,
    parameter int FRAME_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctl                  i_ctl,
    input  logic [PROC_BITS-1:0]  i_proc,
    input  logic [PAGE_BITS-1:0]  i_page,
    input  logic [FRAME_BITS-1:0] i_frame,
    output t_ctl                  o_ctl,
    output logic [PROC_BITS-1:0]  o_proc,
    output logic [PAGE_BITS-1:0]  o_page,
    output logic [FRAME_BITS-1:0] o_frame
);

    // entry
    logic                  r_valid, n_valid;
    logic [PROC_BITS-1:0]  r_proc,  n_proc;
    logic [PAGE_BITS-1:0]  r_page,  n_page;
    logic [FRAME_BITS-1:0] r_frame, n_frame;

    // token toward the next cell
    t_ctl                  r_ctl,    n_ctl;
    logic [FRAME_BITS-1:0] r_tframe, n_tframe;
    logic [PROC_BITS-1:0]  r_tproc;
    logic [PAGE_BITS-1:0]  r_tpage;

    logic w_proc_hit;
    logic w_hit;

    assign w_proc_hit = r_valid && (r_proc == i_proc);
    assign w_hit      = w_proc_hit && (r_page == i_page);

    always_comb begin
        n_valid  = r_valid;
        n_proc   = r_proc;
        n_page   = r_page;
        n_frame  = r_frame;
        n_ctl    = i_ctl;
        n_tframe = i_frame;
        if (i_ctl.valid) begin
            if (i_ctl.fill) begin
                // first free entry on the fill pass takes the request
                if (!r_valid && !i_ctl.found) begin
                    n_valid     = 1'b1;
                    n_proc      = i_proc;
                    n_page      = i_page;
                    n_frame     = i_frame;
                    n_ctl.found = 1'b1;
                end
            end else begin
                case (i_ctl.mode)
                    MODE_LOOKUP: begin
                        if (w_hit && !i_ctl.found) begin
                            n_ctl.found = 1'b1;
                            n_tframe    = r_frame;
                        end
                    end
                    MODE_INSERT: begin
                        if (w_hit && !i_ctl.found) begin
                            n_ctl.found = 1'b1;
                            n_frame     = i_frame;
                        end
                    end
                    MODE_INV_PROC: begin
                        if (w_proc_hit) begin
                            n_valid = 1'b0;
                        end
                    end
                    MODE_INV_PAGE: begin
                        if (w_hit) begin
                            n_valid = 1'b0;
                        end
                    end
                    default: begin
                        n_valid = r_valid;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ctl   <= '0;
        end else begin
            r_valid <= n_valid;
            r_ctl   <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_proc   <= n_proc;
        r_page   <= n_page;
        r_frame  <= n_frame;
        r_tproc  <= i_proc;
        r_tpage  <= i_page;
        r_tframe <= n_tframe;
    end

    assign o_ctl   = r_ctl;
    assign o_proc  = r_tproc;
    assign o_page  = r_tpage;
    assign o_frame = r_tframe;

endmodule

// ===== hdl/tfatlb_checker.sv =====
// ----------------------------------------------------------------------------
// tfatlb_checker
// Port-level checks of the translation buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "tagged_fully_assoc_tlb_top_macros.svh"

module tfatlb_checker #(
    parameter int FRAME_BITS = 20
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic                  i_out_ok,
    input logic [FRAME_BITS-1:0] i_out_frame
);

    // only one item walks the chain at a time
    `TFATLB_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "item accepted while another in flight")

    // failed lookups and inserts carry no frame
    `TFATLB_ASSERT_SAME(a_miss_frame_zero, i_clk, i_rst_n, i_out_valid && !i_out_ok, i_out_frame == '0, "nonzero frame on failed item")

    // a stalled result holds
    `TFATLB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_ok) && $stable(i_out_frame), "stalled result changed")

    // no result straight out of reset
    `TFATLB_ASSERT_SAME(a_reset_quiet, i_clk, i_rst_n, $past(!i_rst_n), !i_out_valid, "result valid right after reset")

endmodule

bind tagged_fully_assoc_tlb_top tfatlb_checker #(
    .FRAME_BITS (FRAME_BITS)
) u_tfatlb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_ok    (o_rsp.ok),
    .i_out_frame (o_rsp.frame_out)
);
